// ----- hw/rtl/dedd_pkg.sv -----
// Shared types, widths and constants for the dual moving-average drift detector.
// No dependencies; every other file of the block imports this package.
package dedd_pkg;

  // Sample format and Q16.16 average format
  localparam int SAMPLE_WIDTH = 16;
  localparam int FRAC_BITS    = 16;
  localparam int AVG_W        = 32;

  // Smoothing factors are Q0.16 with one extra bit so that 1.0 fits
  localparam int ALPHA_FRAC = 16;
  localparam int ALPHA_W    = ALPHA_FRAC + 1;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = {1'b1, {ALPHA_FRAC{1'b0}}};

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [ALPHA_W-1:0] ALPHA_A_RST = ALPHA_W'(6554);
  localparam logic [ALPHA_W-1:0] ALPHA_B_RST = ALPHA_W'(655);
  localparam logic [AVG_W-1:0]   GAP_THR_RST = AVG_W'(65536);

  // Saturation bounds of a signed average
  localparam logic signed [AVG_W-1:0] AVG_MAX = {1'b0, {(AVG_W-1){1'b1}}};
  localparam logic signed [AVG_W-1:0] AVG_MIN = {1'b1, {(AVG_W-1){1'b0}}};

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA_A = 2'd0,
    CFG_ALPHA_B = 2'd1,
    CFG_GAP_THR = 2'd2
  } cfg_idx_e;

  // What the back end does with an item
  typedef enum logic [1:0] {
    OP_RESTART = 2'd0,
    OP_SEED    = 2'd1,
    OP_UPDATE  = 2'd2
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic signed [AVG_W-1:0]  x;
  } item_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha_a;
    logic [ALPHA_W-1:0] alpha_b;
    logic [AVG_W-1:0]   gap_thr;
  } cfg_t;

endpackage

// ----- hw/rtl/dedd_in_if.sv -----
// Input channel: valid/ready handshake carrying a command and one sample.
// Depends on dedd_pkg for the sample width.
interface dedd_in_if import dedd_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic signed [SAMPLE_WIDTH-1:0] sample_value;

  modport source (output valid, cmd, sample_value, input ready);
  modport sink   (input valid, cmd, sample_value, output ready);
endinterface

// ----- hw/rtl/dedd_out_if.sv -----
// Result channel: valid/ready handshake carrying alert, both averages and the gap.
// Depends on dedd_pkg for the average width.
interface dedd_out_if import dedd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    alert;
  logic signed [AVG_W-1:0] fast_avg;
  logic signed [AVG_W-1:0] slow_avg;
  logic [AVG_W-1:0]        gap;

  modport source (output valid, alert, fast_avg, slow_avg, gap, input ready);
  modport sink   (input valid, alert, fast_avg, slow_avg, gap, output ready);
endinterface

// ----- hw/rtl/dedd_front.sv -----
// Front end: accepts items, tracks the seeded flag, classifies each item and
// scales the sample to Q16.16. Depends on dedd_pkg and dedd_in_if.
module dedd_front import dedd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  dedd_in_if.sink    in_ch,
  output item_t      item_o,
  output logic       item_vld_o,
  input  logic       item_rdy_i
);

  // Wide enough for the scaled sample and at least one bit over the average
  localparam int XW = SAMPLE_WIDTH + FRAC_BITS;
  localparam int EW = (XW > AVG_W) ? XW : AVG_W + 1;

  logic  vld_q, vld_d;
  logic  seeded_q, seeded_d;
  item_t item_q, item_d;
  logic  accept;

  logic signed [EW-1:0]    wide;
  logic signed [AVG_W-1:0] x_fix;

  assign in_ch.ready = !vld_q || item_rdy_i;
  assign accept      = in_ch.valid && in_ch.ready;

  // Sample to Q16.16 with saturation
  always_comb begin
    wide = EW'(in_ch.sample_value) <<< FRAC_BITS;
    if (wide > EW'(AVG_MAX)) begin
      x_fix = AVG_MAX;
    end else if (wide < EW'(AVG_MIN)) begin
      x_fix = AVG_MIN;
    end else begin
      x_fix = wide[AVG_W-1:0];
    end
  end

  // Classify: restart, first sample after restart, or regular update
  always_comb begin
    item_d   = item_q;
    seeded_d = seeded_q;
    vld_d    = vld_q && !item_rdy_i;
    if (accept) begin
      vld_d    = 1'b1;
      item_d.x = x_fix;
      if (in_ch.cmd) begin
        item_d.op = OP_RESTART;
        seeded_d  = 1'b0;
      end else begin
        item_d.op = seeded_q ? OP_UPDATE : OP_SEED;
        seeded_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= 1'b0;
      seeded_q <= 1'b0;
    end else begin
      vld_q    <= vld_d;
      seeded_q <= seeded_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_o     = item_q;
  assign item_vld_o = vld_q;

endmodule

// ----- hw/rtl/dedd_queue.sv -----
// Short FIFO of classified items between front and back end.
// Depends on dedd_pkg for the item type and the depth.
module dedd_queue import dedd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  item_t push_item_i,
  input  logic  push_i,
  output logic  not_full_o,
  output item_t pop_item_o,
  output logic  not_empty_o,
  input  logic  pop_i
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  item_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign not_full_o  = (cnt_q != CNT_FULL);
  assign not_empty_o = (cnt_q != '0);
  assign do_push     = push_i && not_full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign pop_item_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ----- hw/rtl/dedd_back.sv -----
// Back end: runs both average updates, then forms gap and alert in the output
// register. Depends on dedd_pkg and dedd_out_if.
module dedd_back import dedd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  item_t      item_i,
  input  logic       item_vld_i,
  output logic       pop_o,
  dedd_out_if.source out_ch
);

  localparam int PROD_W = AVG_W + 1 + ALPHA_W + 1;
  localparam int STEP_W = PROD_W - ALPHA_FRAC;
  localparam int SUM_W  = STEP_W + 1;
  localparam logic signed [PROD_W-1:0] RND_POS = PROD_W'(1 << (ALPHA_FRAC - 1));
  localparam logic signed [PROD_W-1:0] RND_NEG = PROD_W'((1 << (ALPHA_FRAC - 1)) - 1);

  // One update: avg + alpha*(x-avg), rounded half away from zero, saturated
  function automatic logic signed [AVG_W-1:0] ewma_step(
    input logic signed [AVG_W-1:0] avg,
    input logic signed [AVG_W-1:0] x,
    input logic [ALPHA_W-1:0]      alpha
  );
    logic signed [AVG_W:0]    diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] rounded;
    logic signed [STEP_W-1:0] stp;
    logic signed [SUM_W-1:0]  sum;
    diff    = (AVG_W + 1)'(x) - (AVG_W + 1)'(avg);
    prod    = diff * $signed({1'b0, alpha});
    // a negative product takes half minus one, which rounds the tie downward
    rounded = prod + (prod[PROD_W-1] ? RND_NEG : RND_POS);
    stp     = rounded[PROD_W-1:ALPHA_FRAC];
    sum     = SUM_W'(avg) + SUM_W'(stp);
    if (sum > SUM_W'(AVG_MAX)) begin
      ewma_step = AVG_MAX;
    end else if (sum < SUM_W'(AVG_MIN)) begin
      ewma_step = AVG_MIN;
    end else begin
      ewma_step = sum[AVG_W-1:0];
    end
  endfunction

  logic [ALPHA_W-1:0] alpha_fast_q, alpha_fast_d;
  logic [ALPHA_W-1:0] alpha_slow_q, alpha_slow_d;
  logic [ALPHA_W-1:0] a_clamp, b_clamp;

  logic                    s1_vld_q, s1_vld_d;
  logic signed [AVG_W-1:0] fast_q, fast_d;
  logic signed [AVG_W-1:0] slow_q, slow_d;

  logic                    out_vld_q, out_vld_d;
  logic                    alert_q, alert_d;
  logic signed [AVG_W-1:0] fast_out_q, slow_out_q;
  logic [AVG_W-1:0]        gap_q, gap_d;
  logic signed [AVG_W:0]   avg_diff;

  logic out_take, s1_take;

  // Clamp, sort, register alphas; user must change only while idle, unchecked
  always_comb begin
    a_clamp      = (cfg_i.alpha_a > ALPHA_ONE) ? ALPHA_ONE : cfg_i.alpha_a;
    b_clamp      = (cfg_i.alpha_b > ALPHA_ONE) ? ALPHA_ONE : cfg_i.alpha_b;
    alpha_fast_d = (a_clamp > b_clamp) ? a_clamp : b_clamp;
    alpha_slow_d = (a_clamp > b_clamp) ? b_clamp : a_clamp;
  end

  // Stall chain from the output register back to the queue
  assign out_take = !out_vld_q || out_ch.ready;
  assign s1_take  = !s1_vld_q || out_take;
  assign pop_o    = item_vld_i && s1_take;

  // Execute stage: averages are both the state and this stage's payload
  always_comb begin
    fast_d   = fast_q;
    slow_d   = slow_q;
    s1_vld_d = s1_vld_q;
    if (s1_take) begin
      s1_vld_d = item_vld_i;
    end
    if (pop_o) begin
      case (item_i.op)
        OP_RESTART: begin
          fast_d = '0;
          slow_d = '0;
        end
        OP_SEED: begin
          fast_d = item_i.x;
          slow_d = item_i.x;
        end
        OP_UPDATE: begin
          fast_d = ewma_step(fast_q, item_i.x, alpha_fast_q);
          slow_d = ewma_step(slow_q, item_i.x, alpha_slow_q);
        end
        default: begin
          fast_d = fast_q;
          slow_d = slow_q;
        end
      endcase
    end
  end

  // Output stage: gap and threshold compare
  always_comb begin
    avg_diff  = (AVG_W + 1)'(fast_q) - (AVG_W + 1)'(slow_q);
    gap_d     = avg_diff[AVG_W] ? AVG_W'(-avg_diff) : avg_diff[AVG_W-1:0];
    alert_d   = (gap_d > cfg_i.gap_thr);
    out_vld_d = out_take ? s1_vld_q : out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_fast_q <= ALPHA_A_RST;
      alpha_slow_q <= ALPHA_B_RST;
      s1_vld_q     <= 1'b0;
      fast_q       <= '0;
      slow_q       <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      alpha_fast_q <= alpha_fast_d;
      alpha_slow_q <= alpha_slow_d;
      s1_vld_q     <= s1_vld_d;
      fast_q       <= fast_d;
      slow_q       <= slow_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take && s1_vld_q) begin
      alert_q    <= alert_d;
      fast_out_q <= fast_q;
      slow_out_q <= slow_q;
      gap_q      <= gap_d;
    end
  end

  assign out_ch.valid    = out_vld_q;
  assign out_ch.alert    = alert_q;
  assign out_ch.fast_avg = fast_out_q;
  assign out_ch.slow_avg = slow_out_q;
  assign out_ch.gap      = gap_q;

endmodule

// ----- hw/rtl/dual_ewma_drift_detector.sv -----
// Top level of the dual moving-average drift detector: configuration registers,
// front end, item queue and back end. Depends on dedd_pkg and both channel interfaces.
//
// Usage:
//   sample_if carries one item per handshake: cmd = 0 is a sample, cmd = 1 a
//   restart. result_if returns exactly one result per item, in order: alert,
//   fast and slow averages (signed Q16.16) and their gap (unsigned Q16.16).
//   The configuration port (cfg_we_i, cfg_idx_i, cfg_data_i) writes alpha_a,
//   alpha_b or the gap threshold, one register per write; write only while idle.
//   Throughput: one item per cycle while result_if is ready. The limit is the
//   combinational average update loop (multiply, round, add, saturate) in the
//   back end. An accepted item passes through the front register, the queue,
//   the execute stage and the output register before its result is valid.
//   Reset clears the averages, the seeded flag and all valid bits, and loads
//   the registers with alpha_a = 6554, alpha_b = 655, threshold = 1.0.
//   When the receiver stalls, the result holds in the output register, the
//   execute stage and the queue fill up, and sample_if.ready drops once the
//   front register can no longer hand its item on.
module dual_ewma_drift_detector import dedd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  dedd_in_if.sink               sample_if,
  dedd_out_if.source            result_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t  cfg_q, cfg_d;
  item_t front_item, queue_item;
  logic  front_vld, queue_not_full, queue_not_empty, queue_pop;

  // Configuration registers; unknown index is ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ALPHA_A: cfg_d.alpha_a = cfg_data_i[ALPHA_W-1:0];
        CFG_ALPHA_B: cfg_d.alpha_b = cfg_data_i[ALPHA_W-1:0];
        CFG_GAP_THR: cfg_d.gap_thr = cfg_data_i[AVG_W-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha_a <= ALPHA_A_RST;
      cfg_q.alpha_b <= ALPHA_B_RST;
      cfg_q.gap_thr <= GAP_THR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dedd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (sample_if),
    .item_o     (front_item),
    .item_vld_o (front_vld),
    .item_rdy_i (queue_not_full)
  );

  dedd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_item_i (front_item),
    .push_i      (front_vld),
    .not_full_o  (queue_not_full),
    .pop_item_o  (queue_item),
    .not_empty_o (queue_not_empty),
    .pop_i       (queue_pop)
  );

  dedd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .item_i     (queue_item),
    .item_vld_i (queue_not_empty),
    .pop_o      (queue_pop),
    .out_ch     (result_if)
  );

endmodule

// ----- hw/rtl/dedd_checker.sv -----
// Port-level checks of the drift detector's result channel, bound to the top.
// Depends on dedd_pkg and the top level dual_ewma_drift_detector.
module dedd_checker import dedd_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic                    alert_i,
  input logic signed [AVG_W-1:0] fast_avg_i,
  input logic signed [AVG_W-1:0] slow_avg_i,
  input logic [AVG_W-1:0]        gap_i
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // Gap is the absolute difference of the two averages
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> gap_i == ((fast_avg_i >= slow_avg_i) ? AVG_W'(fast_avg_i - slow_avg_i)
                                                        : AVG_W'(slow_avg_i - fast_avg_i)))
    else $error("gap does not match the averages");

  // An alert needs a nonzero gap, so seed and restart results never alert
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && alert_i |-> gap_i != '0)
    else $error("alert with zero gap");

  // Nothing is offered while reset is held (valid may still be unknown at the first edge)
  assert property (@(posedge clk_i)
    !rst_ni |-> out_valid_i !== 1'b1)
    else $error("result valid during reset");

endmodule

bind dual_ewma_drift_detector dedd_checker u_dedd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (result_if.valid),
  .out_ready_i (result_if.ready),
  .alert_i     (result_if.alert),
  .fast_avg_i  (result_if.fast_avg),
  .slow_avg_i  (result_if.slow_avg),
  .gap_i       (result_if.gap)
);
